// File: rtl/gtp_pkg.sv
// shared types, constants and the arctangent lookup table of the go-to-point velocity controller
package gtp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int SQRT_STAGES   = 17;
  localparam int CHAIN_LEN     = (CORDIC_STAGES > SQRT_STAGES) ? CORDIC_STAGES : SQRT_STAGES;
  localparam int CW            = 37;   // cordic x/y width
  localparam int ZW            = 32;   // cordic angle width, 2^-32 turn
  localparam int SW            = 34;   // square root remainder width
  localparam int SHW           = 5;    // cordic shift amount width
  localparam int CFG_AW        = 2;
  localparam int CFG_DW        = 16;

  localparam logic [CFG_AW-1:0] CFG_MAX_ANGULAR  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_CRUISE_SPEED = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ARRIVAL_DIST = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_ALIGN_WINDOW = 2'd3;

  localparam logic [ZW-1:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_t;

  typedef struct packed {
    logic signed [15:0] angular_velocity;
    logic [14:0]        linear_velocity;
    logic               moving;
    logic [16:0]        distance;
    logic [15:0]        heading;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ZW-1:0]        z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0] v;
    logic [SW-1:0] r;
  } sqrt_t;

endpackage

// File: rtl/gtp_cordic_cell.sv
// one vectoring cordic step with its output register
module gtp_cordic_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          bypass,
  input  logic [gtp_pkg::SHW-1:0]       shift,
  input  logic [gtp_pkg::ZW-1:0]        atan,
  input  gtp_pkg::cordic_t              d,
  output gtp_pkg::cordic_t              q_r
);

  gtp_pkg::cordic_t        q_nxt;
  logic signed [gtp_pkg::CW-1:0] xs;
  logic signed [gtp_pkg::CW-1:0] ys;

  assign xs = d.x >>> shift;
  assign ys = d.y >>> shift;

  always_comb begin
    q_nxt = d;
    if (!bypass) begin
      if (d.y > 0) begin
        q_nxt.x = d.x + ys;
        q_nxt.y = d.y - xs;
        q_nxt.z = d.z + atan;
      end else begin
        q_nxt.x = d.x - ys;
        q_nxt.y = d.y + xs;
        q_nxt.z = d.z - atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// File: rtl/gtp_sqrt_cell.sv
// one digit step of the integer square root with its output register
module gtp_sqrt_cell (
  input  logic                    clk,
  input  logic                    en,
  input  logic                    bypass,
  input  logic [gtp_pkg::SW-1:0]  bit_val,
  input  gtp_pkg::sqrt_t          d,
  output gtp_pkg::sqrt_t          q_r
);

  gtp_pkg::sqrt_t          q_nxt;
  logic [gtp_pkg::SW-1:0]  trial;

  assign trial = d.r + bit_val;

  always_comb begin
    q_nxt = d;
    if (!bypass) begin
      if (d.v >= trial) begin
        q_nxt.v = d.v - trial;
        q_nxt.r = (d.r >> 1) + bit_val;
      end else begin
        q_nxt.r = d.r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

// File: rtl/go_to_point_velocity_controller_unit.sv
// top level of the go-to-point velocity controller pipeline
//
// usage: one pose sample per input transaction (target, position, orientation
// quaternion) on in_valid/in_ready/in_data; one command per sample comes back
// on out_valid/out_ready/out_data in the same order.
// the pipeline has CHAIN_LEN + 5 register stages from acceptance to
// out_valid; the depth is set by the row of cordic and square root cells,
// whichever row is longer.
// throughput is one transaction per cycle unless the output stalls: a new
// sample can enter every cycle while earlier ones are still in the cell rows.
// when the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes and in_ready drops; it resumes the cycle out_ready returns.
// configuration: cfg_we writes cfg_wdata to register cfg_addr at once; write
// only while no transaction is in flight.
// reset (rst_n low, synchronous) empties the pipeline and loads the
// configuration registers with their default values.
module go_to_point_velocity_controller_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  gtp_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gtp_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [gtp_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [gtp_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int NCH = gtp_pkg::CHAIN_LEN;
  localparam int NV  = NCH + 5;
  localparam int AB  = gtp_pkg::ANGLE_BITS;
  localparam int CW  = gtp_pkg::CW;
  localparam int ZW  = gtp_pkg::ZW;
  localparam int SW  = gtp_pkg::SW;

  // configuration registers
  logic [14:0] max_ang_r;
  logic [14:0] cruise_r;
  logic [15:0] arr_dist_r;
  logic [14:0] align_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ang_r   <= 15'd16384;
      cruise_r    <= 15'd6144;
      arr_dist_r  <= 16'd77;
      align_win_r <= 15'd104;
    end else if (cfg_we) begin
      case (cfg_addr)
        gtp_pkg::CFG_MAX_ANGULAR:  max_ang_r   <= cfg_wdata[14:0];
        gtp_pkg::CFG_CRUISE_SPEED: cruise_r    <= cfg_wdata[14:0];
        gtp_pkg::CFG_ARRIVAL_DIST: arr_dist_r  <= cfg_wdata;
        gtp_pkg::CFG_ALIGN_WINDOW: align_win_r <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a finished result is stuck
  logic          en;
  logic [NV-1:0] vld_r;

  assign en        = !vld_r[NV-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NV-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NV-2:0], in_valid};
    end
  end

  // stage 0: travel vector and quaternion products
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] dx_sq;
  logic signed [33:0] dy_sq;
  logic signed [31:0] qxy_r, qzw_r, qyy_r, qzz_r;
  logic [31:0]        dxx_r, dyy_r;
  logic signed [16:0] dx_r, dy_r;

  assign dx    = 17'(in_data.target_x) - 17'(in_data.pos_x);
  assign dy    = 17'(in_data.target_y) - 17'(in_data.pos_y);
  assign dx_sq = 34'(dx) * 34'(dx);
  assign dy_sq = 34'(dy) * 34'(dy);

  always_ff @(posedge clk) begin
    if (en) begin
      qxy_r <= 32'(in_data.quat_x) * 32'(in_data.quat_y);
      qzw_r <= 32'(in_data.quat_z) * 32'(in_data.quat_w);
      qyy_r <= 32'(in_data.quat_y) * 32'(in_data.quat_y);
      qzz_r <= 32'(in_data.quat_z) * 32'(in_data.quat_z);
      dxx_r <= dx_sq[31:0];
      dyy_r <= dy_sq[31:0];
      dx_r  <= dx;
      dy_r  <= dy;
    end
  end

  // stage 1: atan2 operands folded into the right half plane
  function automatic gtp_pkg::cordic_t cordic_prep(input logic signed [CW-1:0] y,
                                                    input logic signed [CW-1:0] x);
    gtp_pkg::cordic_t c;
    c.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      c.x = -x;
      c.y = -y;
      c.z = {1'b1, {(ZW-1){1'b0}}};
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

  logic signed [33:0]   num;
  logic signed [33:0]   den;
  logic signed [CW-1:0] bx;
  logic signed [CW-1:0] by;

  assign num = (34'(qxy_r) + 34'(qzw_r)) <<< 1;
  assign den = 34'sd268435456 - ((34'(qyy_r) + 34'(qzz_r)) <<< 1);
  assign bx  = CW'(dx_r) <<< 13;
  assign by  = CW'(dy_r) <<< 13;

  gtp_pkg::cordic_t hc_chain [NCH+1];
  gtp_pkg::cordic_t bc_chain [NCH+1];
  gtp_pkg::sqrt_t   sq_chain [NCH+1];

  always_ff @(posedge clk) begin
    if (en) begin
      hc_chain[0]   <= cordic_prep(CW'(num), CW'(den));
      bc_chain[0]   <= cordic_prep(by, bx);
      sq_chain[0].v <= SW'(dxx_r) + SW'(dyy_r);
      sq_chain[0].r <= '0;
    end
  end

  // rows of cells: heading atan2, bearing atan2 and distance square root
  for (genvar k = 0; k < NCH; k++) begin : g_chain
    localparam int SH = (k < gtp_pkg::SQRT_STAGES) ? 2 * (gtp_pkg::SQRT_STAGES - 1 - k) : 0;

    gtp_cordic_cell u_head_cell (
      .clk    (clk),
      .en     (en),
      .bypass (k >= gtp_pkg::CORDIC_STAGES),
      .shift  (gtp_pkg::SHW'(k)),
      .atan   (gtp_pkg::ATAN_TURNS[k]),
      .d      (hc_chain[k]),
      .q_r    (hc_chain[k+1])
    );

    gtp_cordic_cell u_bear_cell (
      .clk    (clk),
      .en     (en),
      .bypass (k >= gtp_pkg::CORDIC_STAGES),
      .shift  (gtp_pkg::SHW'(k)),
      .atan   (gtp_pkg::ATAN_TURNS[k]),
      .d      (bc_chain[k]),
      .q_r    (bc_chain[k+1])
    );

    gtp_sqrt_cell u_sqrt_cell (
      .clk     (clk),
      .en      (en),
      .bypass  (k >= gtp_pkg::SQRT_STAGES),
      .bit_val ({{(SW-1){1'b0}}, 1'b1} << SH),
      .d       (sq_chain[k]),
      .q_r     (sq_chain[k+1])
    );
  end

  // angle rounding to ANGLE_BITS, a zero vector gives angle zero
  localparam logic [ZW-1:0] ZHALF = ZW'(1) << (31 - AB);

  logic [ZW-1:0] head_z, bear_z;
  logic [AB-1:0] head_q_r, bear_q_r;
  logic [16:0]   dist_q_r;

  assign head_z = (hc_chain[NCH].zero ? '0 : hc_chain[NCH].z) + ZHALF;
  assign bear_z = (bc_chain[NCH].zero ? '0 : bc_chain[NCH].z) + ZHALF;

  always_ff @(posedge clk) begin
    if (en) begin
      head_q_r <= head_z[ZW-1 -: AB];
      bear_q_r <= bear_z[ZW-1 -: AB];
      dist_q_r <= sq_chain[NCH].r[16:0];
    end
  end

  // heading error wrapped to a half turn either way, scaled by the gain
  localparam logic [AB-1:0] HALF_A = AB'(1) << (AB - 1);

  logic [AB-1:0]    err_e;
  logic             err_neg;
  logic [AB-1:0]    err_mag;
  logic             aligned;
  logic [AB+14:0]   prod_r;
  logic             neg_r, moving_r, aligned_r;
  logic [16:0]      dist_r;
  logic [AB-1:0]    head_r;

  assign err_e   = bear_q_r - head_q_r;
  assign err_neg = err_e > HALF_A;
  assign err_mag = err_neg ? -err_e : err_e;
  assign aligned = {err_mag, 16'b0} < (AB+16)'({align_win_r, {AB{1'b0}}});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r    <= (AB+15)'(err_mag) * (AB+15)'(max_ang_r);
      neg_r     <= err_neg;
      moving_r  <= dist_q_r > 17'(arr_dist_r);
      aligned_r <= aligned;
      dist_r    <= dist_q_r;
      head_r    <= head_q_r;
    end
  end

  // rounding, sign and saturation into the output register
  logic [AB+14:0]     wsum;
  logic [15:0]        wmag;
  logic signed [15:0] wval;
  logic [AB+15:0]     head_wide;
  gtp_pkg::out_t      out_nxt;

  assign wsum      = prod_r + ((AB+15)'(1) << (AB - 2));
  assign wmag      = wsum[AB+14 : AB-1];
  assign head_wide = {head_r, 16'b0} >> AB;

  always_comb begin
    if (neg_r) begin
      wval = (wmag > 16'd32768) ? 16'sh8000 : -wmag;
    end else begin
      wval = (wmag > 16'd32767) ? 16'sh7fff : wmag;
    end
    out_nxt.angular_velocity = wval;
    out_nxt.linear_velocity  = (moving_r && aligned_r) ? cruise_r : '0;
    out_nxt.moving           = moving_r;
    out_nxt.distance         = dist_r;
    out_nxt.heading          = head_wide[15:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_nxt;
    end
  end

  // checks
  a_speed_needs_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.linear_velocity == '0 || out_data.moving))
    else $error("forward speed without motion");

  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result present right after reset");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

// File: dv/tb_go_to_point_velocity_controller_unit.sv
// self-checking testbench of the go-to-point velocity controller pipeline
module tb_go_to_point_velocity_controller_unit;

  localparam int N_RANDOM    = 1900;
  localparam int PIPE_DEPTH  = gtp_pkg::CHAIN_LEN + 5;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  gtp_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  gtp_pkg::out_t out_data;
  logic cfg_we = 1'b0;
  logic [gtp_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [gtp_pkg::CFG_DW-1:0] cfg_wdata = '0;

  go_to_point_velocity_controller_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // shadow copy of the configuration registers
  logic [14:0] turn_gain;
  logic [14:0] cruise_speed;
  logic [15:0] arrive_dist;
  logic [14:0] align_window;

  gtp_pkg::out_t cmd_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit receiver_hold = 1'b0;   // long receiver stall in progress
  bit stim_done = 1'b0;

  // directed stimulus: payload plus an optional typed-in expected result
  typedef struct {
    gtp_pkg::in_t  pose;
    bit            has_fixed;
    gtp_pkg::out_t fixed;
  } pose_row_t;
  pose_row_t pose_table[$];

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  // vectoring cordic, angle in 2^-32 turn
  function automatic logic [31:0] angle_of(longint y, longint x);
    logic [31:0] z;
    longint xs, ys;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < gtp_pkg::CORDIC_STAGES && i < 24; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += gtp_pkg::ATAN_TURNS[i];
      end else begin
        x -= ys; y += xs; z -= gtp_pkg::ATAN_TURNS[i];
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] round_angle(logic [31:0] z);
    logic [31:0] t;
    t = z + (32'd1 << (31 - gtp_pkg::ANGLE_BITS));
    return 16'(t >> (32 - gtp_pkg::ANGLE_BITS));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic gtp_pkg::out_t steer_command(gtp_pkg::in_t p);
    gtp_pkg::out_t o;
    longint dx, dy, num, den, err, w;
    longint unsigned mag, dist_val, wmag;
    logic [15:0] head, bear, e;
    bit moving, aligned;
    dx = longint'(p.target_x) - longint'(p.pos_x);
    dy = longint'(p.target_y) - longint'(p.pos_y);
    num = 2 * (longint'(p.quat_x) * p.quat_y + longint'(p.quat_z) * p.quat_w);
    den = (64'sd1 <<< 28) - 2 * (longint'(p.quat_y) * p.quat_y + longint'(p.quat_z) * p.quat_z);
    head = round_angle(angle_of(num, den));
    bear = round_angle(angle_of(dy * 8192, dx * 8192));
    e = bear - head;
    err = (e > 16'h8000) ? longint'(e) - 65536 : longint'(e);
    mag = (err < 0) ? -err : err;
    dist_val = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
    moving = dist_val > arrive_dist;
    aligned = (mag << 16) < (longint'(align_window) << gtp_pkg::ANGLE_BITS);
    wmag = (mag * turn_gain + (64'd1 << (gtp_pkg::ANGLE_BITS - 2))) >> (gtp_pkg::ANGLE_BITS - 1);
    w = (err < 0) ? -longint'(wmag) : longint'(wmag);
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    o.angular_velocity = 16'(w);
    o.linear_velocity = (moving && aligned) ? cruise_speed : '0;
    o.moving = moving;
    o.distance = 17'(dist_val);
    o.heading = head;
    return o;
  endfunction

  task automatic write_reg(logic [gtp_pkg::CFG_AW-1:0] idx, logic [gtp_pkg::CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      gtp_pkg::CFG_MAX_ANGULAR:  turn_gain = val[14:0];
      gtp_pkg::CFG_CRUISE_SPEED: cruise_speed = val[14:0];
      gtp_pkg::CFG_ARRIVAL_DIST: arrive_dist = val;
      default:                   align_window = val[14:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop offering, then wait until the pipeline has drained
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (cmd_queue.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  // offer one pose; stays valid until taken, new payload only after acceptance
  task automatic send_pose(gtp_pkg::in_t p, bit has_fixed, gtp_pkg::out_t fixed);
    gtp_pkg::out_t pred;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = steer_command(p);
    if (has_fixed && pred != fixed)
      $display("typed-in expectation disagrees with predictor: %h vs %h", fixed, pred);
    cmd_queue.push_back(has_fixed ? fixed : pred);
    @(negedge clk);
  endtask

  function automatic gtp_pkg::in_t random_pose();
    gtp_pkg::in_t p;
    int mode;
    p = gtp_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      // realistic: unit-ish quaternion, in half of them a nearby target
      p.quat_x = 16'($signed($urandom_range(0, 32768)) - 16384);
      p.quat_y = 16'($signed($urandom_range(0, 32768)) - 16384);
      p.quat_z = 16'($signed($urandom_range(0, 32768)) - 16384);
      p.quat_w = 16'($signed($urandom_range(0, 32768)) - 16384);
      if (mode < 3) begin
        p.target_x = p.pos_x + 16'($signed($urandom_range(0, 400)) - 200);
        p.target_y = p.pos_y + 16'($signed($urandom_range(0, 400)) - 200);
      end
    end else if (mode == 6) begin
      // pure yaw rotation, random target
      p.quat_x = '0;
      p.quat_y = '0;
      p.quat_w = 16'($signed($urandom_range(0, 32768)) - 16384);
      p.quat_z = 16'($signed($urandom_range(0, 32768)) - 16384);
    end
    return p;
  endfunction

  function automatic gtp_pkg::in_t mk_pose(int tx, int ty, int px, int py,
                                           int qx, int qy, int qz, int qw);
    gtp_pkg::in_t p;
    p.target_x = 16'(tx); p.target_y = 16'(ty);
    p.pos_x = 16'(px);    p.pos_y = 16'(py);
    p.quat_x = 16'(qx);   p.quat_y = 16'(qy);
    p.quat_z = 16'(qz);   p.quat_w = 16'(qw);
    return p;
  endfunction

  function automatic void add_row(gtp_pkg::in_t p);
    pose_row_t r;
    r.pose = p;
    r.has_fixed = 1'b0;
    r.fixed = '0;
    pose_table.push_back(r);
  endfunction

  function automatic void add_fixed(gtp_pkg::in_t p, gtp_pkg::out_t o);
    pose_row_t r;
    r.pose = p;
    r.has_fixed = 1'b1;
    r.fixed = o;
    pose_table.push_back(r);
  endfunction

  function automatic void build_table();
    gtp_pkg::out_t o;
    // all zeros: zero travel vector, zero quaternion, heading 0 and bearing 0
    o = '0;
    add_fixed(mk_pose(0, 0, 0, 0, 0, 0, 0, 0), o);
    // identity quaternion, target straight ahead far away: aligned, cruising
    o.angular_velocity = '0; o.linear_velocity = 15'd6144; o.moving = 1'b1;
    o.distance = 17'd256; o.heading = '0;
    add_fixed(mk_pose(256, 0, 0, 0, 0, 0, 0, 16384), o);
    // target straight behind: error of exactly half a turn gives +max speed
    o.angular_velocity = 16'sd16384; o.linear_velocity = '0; o.moving = 1'b1;
    o.distance = 17'd256; o.heading = '0;
    add_fixed(mk_pose(-256, 0, 0, 0, 0, 0, 0, 16384), o);
    // extremes of position: longest travel vectors
    add_row(mk_pose(32767, 32767, -32768, -32768, 0, 0, 0, 16384));
    add_row(mk_pose(-32768, -32768, 32767, 32767, 0, 0, 16384, 0));
    add_row(mk_pose(-32768, 32767, 32767, -32768, 16384, 16384, 16384, 16384));
    add_row(mk_pose(32767, -32768, -32768, 32767, -16384, -16384, -16384, -16384));
    // target on each axis and exactly at the arrival distance
    add_row(mk_pose(0, 256, 0, 0, 0, 0, 0, 16384));
    add_row(mk_pose(0, -256, 0, 0, 0, 0, 0, 16384));
    add_row(mk_pose(77, 0, 0, 0, 0, 0, 0, 16384));
    add_row(mk_pose(78, 0, 0, 0, 0, 0, 0, 16384));
    // yaw quarter turns and degenerate quaternions
    add_row(mk_pose(100, 100, 0, 0, 0, 0, 11585, 11585));
    add_row(mk_pose(100, 100, 0, 0, 0, 0, -11585, 11585));
    add_row(mk_pose(5, -7, 3, 2, 16384, 0, 0, 0));
    add_row(mk_pose(5, -7, 3, 2, 0, 16384, 0, 0));
    add_row(mk_pose(-900, 40, 1, 1, -1, 1, -1, 1));
    // out-of-range quaternion components
    add_row(mk_pose(300, -300, 0, 0, 32767, -32768, 32767, -32768));
    add_row(mk_pose(300, -300, 0, 0, -32768, 32767, -32768, 32767));
  endfunction

  // receiver: random stalls per transaction, plus one long hold-off
  initial begin : receiver
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (receiver_hold) begin
        out_ready <= 1'b0;
      end else begin
        gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
        while (!(out_valid && out_ready)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    gtp_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cmd_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction %h", out_data);
      end else begin
        want = cmd_queue.pop_front();
        if (out_data.angular_velocity !== want.angular_velocity ||
            out_data.linear_velocity !== want.linear_velocity ||
            out_data.moving !== want.moving ||
            out_data.distance !== want.distance ||
            out_data.heading !== want.heading) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp w=%0d v=%0d mv=%0b d=%0d h=%0d, got w=%0d v=%0d mv=%0b d=%0d h=%0d",
                     want.angular_velocity, want.linear_velocity, want.moving,
                     want.distance, want.heading, out_data.angular_velocity,
                     out_data.linear_velocity, out_data.moving, out_data.distance,
                     out_data.heading);
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_go_to_point_velocity_controller_unit: done, errors");
      $finish;
    end
  end

  // long hold-off: the receiver stops while the sender keeps offering
  initial begin : pressure
    wait (pose_table.size() != 0 && stim_done == 1'b0);
    repeat (900) @(negedge clk);
    receiver_hold = 1'b1;
    repeat (150) @(negedge clk);
    receiver_hold = 1'b0;
  end

  initial begin : stimulus
    int phase;
    turn_gain = 15'd16384;
    cruise_speed = 15'd6144;
    arrive_dist = 16'd77;
    align_window = 15'd104;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    build_table();
    foreach (pose_table[i])
      send_pose(pose_table[i].pose, pose_table[i].has_fixed, pose_table[i].fixed);

    // random part over several register settings, extremes included
    for (phase = 0; phase < 5; phase++) begin
      drain_pipe();
      case (phase)
        0: begin
          write_reg(gtp_pkg::CFG_MAX_ANGULAR, 16'd32767);
          write_reg(gtp_pkg::CFG_CRUISE_SPEED, 16'd32767);
          write_reg(gtp_pkg::CFG_ARRIVAL_DIST, 16'd0);
          write_reg(gtp_pkg::CFG_ALIGN_WINDOW, 16'd32767);
        end
        1: begin
          write_reg(gtp_pkg::CFG_MAX_ANGULAR, 16'd0);
          write_reg(gtp_pkg::CFG_CRUISE_SPEED, 16'd0);
          write_reg(gtp_pkg::CFG_ARRIVAL_DIST, 16'd65535);
          write_reg(gtp_pkg::CFG_ALIGN_WINDOW, 16'd0);
        end
        2: begin
          write_reg(gtp_pkg::CFG_MAX_ANGULAR, 16'($urandom_range(0, 32767)));
          write_reg(gtp_pkg::CFG_CRUISE_SPEED, 16'($urandom_range(0, 32767)));
          write_reg(gtp_pkg::CFG_ARRIVAL_DIST, 16'($urandom_range(0, 400)));
          write_reg(gtp_pkg::CFG_ALIGN_WINDOW, 16'($urandom_range(0, 4000)));
        end
        3: begin
          write_reg(gtp_pkg::CFG_MAX_ANGULAR, 16'd16384);
          write_reg(gtp_pkg::CFG_CRUISE_SPEED, 16'd6144);
          write_reg(gtp_pkg::CFG_ARRIVAL_DIST, 16'd77);
          write_reg(gtp_pkg::CFG_ALIGN_WINDOW, 16'd104);
        end
        default: begin
          // upper data bit set on narrow registers
          write_reg(gtp_pkg::CFG_MAX_ANGULAR, 16'hFFFF);
          write_reg(gtp_pkg::CFG_CRUISE_SPEED, 16'hAAAA);
          write_reg(gtp_pkg::CFG_ARRIVAL_DIST, 16'h5555);
          write_reg(gtp_pkg::CFG_ALIGN_WINDOW, 16'hC000);
        end
      endcase
      repeat (N_RANDOM / 5)
        send_pose(random_pose(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    stim_done = 1'b1;
    fork
      while (cmd_queue.size() != 0) @(negedge clk);
      begin
        repeat (STALL_LIMIT * 4) @(negedge clk);
      end
    join_any
    disable fork;
    if (cmd_queue.size() != 0) begin
      $display("tb_go_to_point_velocity_controller_unit: done, errors");
      $finish;
    end else begin
      repeat (PIPE_DEPTH + 4) @(negedge clk);
      if (mismatches == 0)
        $display("tb_go_to_point_velocity_controller_unit: done, clean");
      else
        $display("tb_go_to_point_velocity_controller_unit: done, errors");
      $finish;
    end
  end

endmodule

// File: files.f
rtl/gtp_pkg.sv
rtl/gtp_cordic_cell.sv
rtl/gtp_sqrt_cell.sv
rtl/go_to_point_velocity_controller_unit.sv
dv/tb_go_to_point_velocity_controller_unit.sv
